### hdl/one_wire_bus_master_top_macros.svh
// Assertion macros shared by the 1-Wire master checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ONE_WIRE_BUS_MASTER_TOP_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OWBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("owbm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define OWBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("owbm assertion failed");

`endif

### hdl/owbm_pkg.sv
// Shared types and constants of the 1-Wire bus master.
// No dependencies; used by every module of the block.
package owbm_pkg;

    localparam int MAX_BYTES  = 32;
    localparam int TIME_WIDTH = 10;
    localparam int NUM_CFG    = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_CFG);
    localparam int IDX_W      = $clog2(MAX_BYTES);
    localparam int CNT_W      = $clog2(MAX_BYTES + 1);

    typedef logic [TIME_WIDTH-1:0] t_time;

    // Item operations
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Timing register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW  = 3'd0,
        CFG_PRESENCE   = 3'd1,
        CFG_RECOVERY   = 3'd2,
        CFG_SLOT_HOLD  = 3'd3,
        CFG_BIT_GAP    = 3'd4,
        CFG_BYTE_GAP   = 3'd5,
        CFG_START_LOW  = 3'd6,
        CFG_SAMPLE     = 3'd7
    } t_cfg_idx;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_PULLUP      = 2'd1,
        ERR_NO_PRESENCE = 2'd2
    } t_err;

    // Bus sequencer phases, one-hot
    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_RESET_LOW = 10'b00_0000_0010,
        PH_PRESENCE  = 10'b00_0000_0100,
        PH_RECOVERY  = 10'b00_0000_1000,
        PH_TX_START  = 10'b00_0001_0000,
        PH_TX_HOLD   = 10'b00_0010_0000,
        PH_TX_GAP    = 10'b00_0100_0000,
        PH_RX_START  = 10'b00_1000_0000,
        PH_RX_WAIT   = 10'b01_0000_0000,
        PH_RX_GAP    = 10'b10_0000_0000
    } t_phase;

    // One result transaction
    typedef struct packed {
        logic             line_drive;
        logic             busy_res;
        logic             done_res;
        logic [1:0]       error_code;
        logic             rx_valid;
        logic [7:0]       rx_byte;
        logic [IDX_W-1:0] rx_index;
    } t_result;

    // Timing register values after reset
    function automatic t_time cfg_reset_val(input t_cfg_idx idx);
        t_time val;
        unique case (idx)
            CFG_RESET_LOW: val = TIME_WIDTH'(480);
            CFG_PRESENCE:  val = TIME_WIDTH'(65);
            CFG_RECOVERY:  val = TIME_WIDTH'(480);
            CFG_SLOT_HOLD: val = TIME_WIDTH'(65);
            CFG_BIT_GAP:   val = TIME_WIDTH'(5);
            CFG_BYTE_GAP:  val = TIME_WIDTH'(500);
            CFG_START_LOW: val = TIME_WIDTH'(6);
            CFG_SAMPLE:    val = TIME_WIDTH'(1);
            default:       val = '0;
        endcase
        return val;
    endfunction

endpackage

### hdl/owbm_skid.sv
// Output register with a one-entry skid buffer for result transactions.
// Depends on owbm_pkg for the result struct.
module owbm_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  owbm_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    output owbm_pkg::t_result o_data,
    input  logic              i_stall
);
    import owbm_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    out_fire;

    assign out_fire = r_out_valid && !i_stall;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    // Payload; the skid only fills while the output register is held
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || !i_stall) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

### hdl/one_wire_bus_master_top.sv
// Top level of the 1-Wire bus master: timing registers, transmit store, bus sequencer.
// Depends on owbm_pkg and owbm_skid.
//
// Each input transaction (load, start, one-microsecond tick or no-op) is handled in
// the cycle it is accepted: the sequencer state and the transmit store update at that
// edge, and the single result is registered in the output register, or in the skid
// buffer while the output is held, at the same edge. One transaction per clock is
// sustained while the output is not stalled. The output register is backed by a
// one-entry skid buffer, so the input is stalled only when both are full. All bus
// timing is counted in ticks supplied as transactions, not in clock cycles.
module one_wire_bus_master_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [owbm_pkg::TIME_WIDTH-1:0]     i_cfg_data,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic [owbm_pkg::IDX_W-1:0]          i_load_index,
    input  logic [7:0]                          i_load_byte,
    input  logic [owbm_pkg::CNT_W-1:0]          i_send_count,
    input  logic [owbm_pkg::CNT_W-1:0]          i_receive_count,
    input  logic                                i_line_level,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_line_drive,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic [1:0]                          o_error_code,
    output logic                                o_rx_valid,
    output logic [7:0]                          o_rx_byte,
    output logic [owbm_pkg::IDX_W-1:0]          o_rx_index
);
    import owbm_pkg::*;

    // Timing registers and transmit store
    t_time      r_cfg [NUM_CFG];
    logic [7:0] r_tx_store [MAX_BYTES];

    // Sequencer state
    t_phase           r_phase,     n_phase;
    t_time            r_countdown, n_countdown;
    logic [2:0]       r_bit_pos,   n_bit_pos;
    logic [CNT_W-1:0] r_byte_pos,  n_byte_pos;
    logic [7:0]       r_rx_shift,  n_rx_shift;
    logic [CNT_W-1:0] r_tx_total,  n_tx_total;
    logic [CNT_W-1:0] r_rx_total,  n_rx_total;
    logic [1:0]       r_fault,     n_fault;
    logic             r_drive,     n_drive;

    logic       in_accept;
    logic       res_done;
    logic       res_rxv;
    logic [7:0] res_rxb;
    logic [IDX_W-1:0] res_rxi;
    logic [7:0] tx_byte;
    logic [7:0] rx_merged;
    t_result    res;
    t_result    out_data;

    assign in_accept = i_in_valid && !o_in_stall;

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
        return (cnt > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : cnt;
    endfunction

    // Timing register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CFG; k++) begin
                r_cfg[k] <= cfg_reset_val(t_cfg_idx'(k));
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Transmit store loads; contents undefined until written
    always_ff @(posedge i_clk) begin
        if (in_accept && t_op'(i_op) == OP_LOAD
            && {1'b0, i_load_index} < (IDX_W + 1)'(MAX_BYTES)) begin
            r_tx_store[i_load_index] <= i_load_byte;
        end
    end

    assign tx_byte = r_tx_store[r_byte_pos[IDX_W-1:0]];

    always_comb begin
        rx_merged = r_rx_shift;
        rx_merged[r_bit_pos] = r_rx_shift[r_bit_pos] | i_line_level;
    end

    // Sequencer next state and result
    always_comb begin
        n_phase     = r_phase;
        n_countdown = r_countdown;
        n_bit_pos   = r_bit_pos;
        n_byte_pos  = r_byte_pos;
        n_rx_shift  = r_rx_shift;
        n_tx_total  = r_tx_total;
        n_rx_total  = r_rx_total;
        n_fault     = r_fault;
        n_drive     = r_drive;
        res_done    = 1'b0;
        res_rxv     = 1'b0;
        res_rxb     = '0;
        res_rxi     = '0;

        if (in_accept) begin
            unique case (t_op'(i_op))
                OP_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_tx_total = sat_count(i_send_count);
                        n_rx_total = sat_count(i_receive_count);
                        n_byte_pos = '0;
                        n_bit_pos  = '0;
                        n_rx_shift = '0;
                        if (!i_line_level) begin
                            // bus held low: no pull-up
                            n_fault     = ERR_PULLUP;
                            n_drive     = 1'b1;
                            n_phase     = PH_IDLE;
                            n_countdown = '0;
                            res_done    = 1'b1;
                        end else begin
                            n_fault     = ERR_NONE;
                            n_drive     = 1'b0;
                            n_phase     = PH_RESET_LOW;
                            n_countdown = r_cfg[CFG_RESET_LOW];
                        end
                    end
                end
                OP_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        if (r_countdown > TIME_WIDTH'(1)) begin
                            n_countdown = r_countdown - TIME_WIDTH'(1);
                        end else begin
                            // phase timer expired
                            unique case (r_phase)
                                PH_RESET_LOW: begin
                                    n_drive     = 1'b1;
                                    n_phase     = PH_PRESENCE;
                                    n_countdown = r_cfg[CFG_PRESENCE];
                                end
                                PH_PRESENCE: begin
                                    if (i_line_level) begin
                                        n_fault     = ERR_NO_PRESENCE;
                                        n_drive     = 1'b1;
                                        n_phase     = PH_IDLE;
                                        n_countdown = '0;
                                        res_done    = 1'b1;
                                    end else begin
                                        n_byte_pos  = '0;
                                        n_bit_pos   = '0;
                                        n_phase     = PH_RECOVERY;
                                        n_countdown = r_cfg[CFG_RECOVERY];
                                    end
                                end
                                PH_RECOVERY, PH_TX_GAP: begin
                                    if (r_byte_pos < r_tx_total) begin
                                        n_drive     = 1'b0;
                                        n_phase     = PH_TX_START;
                                        n_countdown = r_cfg[CFG_START_LOW];
                                    end else if (r_rx_total != '0) begin
                                        // lead-in gap before the first read slot
                                        n_byte_pos  = '0;
                                        n_bit_pos   = '0;
                                        n_drive     = 1'b1;
                                        n_phase     = PH_RX_GAP;
                                        n_countdown = r_cfg[CFG_BIT_GAP];
                                    end else begin
                                        n_fault     = ERR_NONE;
                                        n_drive     = 1'b1;
                                        n_phase     = PH_IDLE;
                                        n_countdown = '0;
                                        res_done    = 1'b1;
                                    end
                                end
                                PH_TX_START: begin
                                    n_drive     = tx_byte[r_bit_pos];
                                    n_phase     = PH_TX_HOLD;
                                    n_countdown = r_cfg[CFG_SLOT_HOLD];
                                end
                                PH_TX_HOLD: begin
                                    n_drive   = 1'b1;
                                    n_bit_pos = r_bit_pos + 3'd1;
                                    n_phase   = PH_TX_GAP;
                                    if (r_bit_pos == 3'd7) begin
                                        n_byte_pos  = r_byte_pos + CNT_W'(1);
                                        n_countdown = r_cfg[CFG_BYTE_GAP];
                                    end else begin
                                        n_countdown = r_cfg[CFG_BIT_GAP];
                                    end
                                end
                                PH_RX_START: begin
                                    n_drive     = 1'b1;
                                    n_phase     = PH_RX_WAIT;
                                    n_countdown = r_cfg[CFG_SAMPLE];
                                end
                                PH_RX_WAIT: begin
                                    n_rx_shift = rx_merged;
                                    n_bit_pos  = r_bit_pos + 3'd1;
                                    n_phase    = PH_RX_GAP;
                                    if (r_bit_pos == 3'd7) begin
                                        res_rxv     = 1'b1;
                                        res_rxb     = rx_merged;
                                        res_rxi     = r_byte_pos[IDX_W-1:0];
                                        n_byte_pos  = r_byte_pos + CNT_W'(1);
                                        n_countdown = r_cfg[CFG_BYTE_GAP];
                                    end else begin
                                        n_countdown = r_cfg[CFG_BIT_GAP];
                                    end
                                end
                                PH_RX_GAP: begin
                                    if (r_byte_pos < r_rx_total) begin
                                        if (r_bit_pos == 3'd0) begin
                                            n_rx_shift = '0;
                                        end
                                        n_drive     = 1'b0;
                                        n_phase     = PH_RX_START;
                                        n_countdown = r_cfg[CFG_START_LOW];
                                    end else begin
                                        n_fault     = ERR_NONE;
                                        n_drive     = 1'b1;
                                        n_phase     = PH_IDLE;
                                        n_countdown = '0;
                                        res_done    = 1'b1;
                                    end
                                end
                                default: begin
                                    n_fault     = ERR_NONE;
                                    n_drive     = 1'b1;
                                    n_phase     = PH_IDLE;
                                    n_countdown = '0;
                                    res_done    = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                default: ; // loads handled by the store, no-op does nothing
            endcase
        end
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_countdown <= '0;
            r_bit_pos   <= '0;
            r_byte_pos  <= '0;
            r_rx_shift  <= '0;
            r_tx_total  <= '0;
            r_rx_total  <= '0;
            r_fault     <= ERR_NONE;
            r_drive     <= 1'b1;
        end else begin
            r_phase     <= n_phase;
            r_countdown <= n_countdown;
            r_bit_pos   <= n_bit_pos;
            r_byte_pos  <= n_byte_pos;
            r_rx_shift  <= n_rx_shift;
            r_tx_total  <= n_tx_total;
            r_rx_total  <= n_rx_total;
            r_fault     <= n_fault;
            r_drive     <= n_drive;
        end
    end

    // Result transaction
    always_comb begin
        res.line_drive = n_drive;
        res.busy_res   = (n_phase != PH_IDLE);
        res.done_res   = res_done;
        res.error_code = n_fault;
        res.rx_valid   = res_rxv;
        res.rx_byte    = res_rxb;
        res.rx_index   = res_rxi;
    end

    owbm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (res),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_stall (i_out_stall)
    );

    assign o_line_drive = out_data.line_drive;
    assign o_busy_res   = out_data.busy_res;
    assign o_done_res   = out_data.done_res;
    assign o_error_code = out_data.error_code;
    assign o_rx_valid   = out_data.rx_valid;
    assign o_rx_byte    = out_data.rx_byte;
    assign o_rx_index   = out_data.rx_index;

endmodule

### hdl/owbm_checker.sv
// Port-level checker for the 1-Wire bus master, bound to the top level.
// Depends on owbm_pkg and one_wire_bus_master_top_macros.svh.
`include "one_wire_bus_master_top_macros.svh"

module owbm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [owbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [owbm_pkg::TIME_WIDTH-1:0] i_cfg_data,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic [1:0]                      i_op,
    input logic [owbm_pkg::IDX_W-1:0]      i_load_index,
    input logic [7:0]                      i_load_byte,
    input logic [owbm_pkg::CNT_W-1:0]      i_send_count,
    input logic [owbm_pkg::CNT_W-1:0]      i_receive_count,
    input logic                            i_line_level,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_line_drive,
    input logic                            o_busy_res,
    input logic                            o_done_res,
    input logic [1:0]                      o_error_code,
    input logic                            o_rx_valid,
    input logic [7:0]                      o_rx_byte,
    input logic [owbm_pkg::IDX_W-1:0]      o_rx_index
);
    import owbm_pkg::*;

    // A held result transaction keeps its payload
    `OWBM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_rx_byte) && $stable(o_line_drive))

    // A finished transfer is no longer busy
    `OWBM_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res)

    // A received byte arrives mid-transfer, never with the end
    `OWBM_ASSERT_IMP(a_rx_busy, i_clk, i_rst_n, o_out_valid && o_rx_valid, o_busy_res && !o_done_res)

    // An error code only stands while idle, and the bus is released then
    `OWBM_ASSERT_IMP(a_err_idle, i_clk, i_rst_n, o_out_valid && (o_error_code != ERR_NONE), !o_busy_res && o_line_drive)

    // Receive fields are zero without a received byte
    `OWBM_ASSERT_IMP(a_rx_zero, i_clk, i_rst_n, o_out_valid && !o_rx_valid, (o_rx_byte == 8'd0) && (o_rx_index == '0))

endmodule

bind one_wire_bus_master_top owbm_checker u_owbm_checker (.*);

### bench/one_wire_bus_master_top_tb.sv
// Self-checking testbench for the 1-Wire bus master top level.
// Depends on owbm_pkg and one_wire_bus_master_top; predicts every result transaction
// in step with the stimulus and compares field by field at the output channel.
`timescale 1ns / 100ps

module one_wire_bus_master_top_tb;
    import owbm_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 2000;

    // One input transaction
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [7:0]       lbyte;
        logic [CNT_W-1:0] scount;
        logic [CNT_W-1:0] rcount;
        logic             level;
    } bus_item_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [TIME_WIDTH-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_op = '0;
    logic [IDX_W-1:0]      i_load_index = '0;
    logic [7:0]            i_load_byte = '0;
    logic [CNT_W-1:0]      i_send_count = '0;
    logic [CNT_W-1:0]      i_receive_count = '0;
    logic                  i_line_level = 1'b1;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_line_drive;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [1:0]            o_error_code;
    logic                  o_rx_valid;
    logic [7:0]            o_rx_byte;
    logic [IDX_W-1:0]      o_rx_index;

    one_wire_bus_master_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_load_index    (i_load_index),
        .i_load_byte     (i_load_byte),
        .i_send_count    (i_send_count),
        .i_receive_count (i_receive_count),
        .i_line_level    (i_line_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_drive    (o_line_drive),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_error_code    (o_error_code),
        .o_rx_valid      (o_rx_valid),
        .o_rx_byte       (o_rx_byte),
        .o_rx_index      (o_rx_index)
    );

    always #2 i_clk = ~i_clk;

    // Transaction queues shared by stimulus, driver and monitor
    bus_item_t pending_items[$];
    t_result   expected_results[$];

    // Run control
    bit idle_on     = 1'b1;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;
    bit counting    = 1'b0;
    int rand_items  = 0;
    int mismatches  = 0;
    int quiet_cycles = 0;
    int gap_left    = 0;
    int hold_left   = 0;
    int burst_left  = 0;
    t_time next_timing[NUM_CFG];

    // ------------------------------------------------------------------
    // Bus sequencer prediction state
    // ------------------------------------------------------------------
    t_time            tim_regs[NUM_CFG] = '{480, 65, 480, 65, 5, 500, 6, 1};
    t_phase           bus_phase = PH_IDLE;
    t_time            bus_countdown = '0;
    logic [7:0]       tx_mem[MAX_BYTES];
    logic [2:0]       bit_idx = '0;
    logic [CNT_W-1:0] byte_idx = '0;
    logic [CNT_W-1:0] tx_cnt = '0;
    logic [CNT_W-1:0] rx_cnt = '0;
    logic [7:0]       rx_acc = '0;
    t_err             err_code = ERR_NONE;
    logic             drive_lvl = 1'b1;
    t_result          res_now;

    function automatic void arm(input t_phase p, input t_cfg_idx r);
        bus_phase = p;
        bus_countdown = tim_regs[r];
    endfunction

    function automatic void close_xfer(input t_err e);
        err_code = e;
        drive_lvl = 1'b1;
        bus_phase = PH_IDLE;
        bus_countdown = '0;
        res_now.done_res = 1'b1;
    endfunction

    function automatic void next_rx_slot();
        if (byte_idx < rx_cnt) begin
            if (bit_idx == 0)
                rx_acc = '0;
            drive_lvl = 1'b0;
            arm(PH_RX_START, CFG_START_LOW);
        end else begin
            close_xfer(ERR_NONE);
        end
    endfunction

    function automatic void next_tx_slot();
        if (byte_idx < tx_cnt) begin
            drive_lvl = 1'b0;
            arm(PH_TX_START, CFG_START_LOW);
        end else if (rx_cnt > 0) begin
            // lead-in gap before the first read slot
            byte_idx = '0;
            bit_idx = '0;
            drive_lvl = 1'b1;
            arm(PH_RX_GAP, CFG_BIT_GAP);
        end else begin
            close_xfer(ERR_NONE);
        end
    endfunction

    // Timed phase ran out on this tick
    function automatic void phase_expired(input logic lvl);
        case (bus_phase)
            PH_RESET_LOW: begin
                drive_lvl = 1'b1;
                arm(PH_PRESENCE, CFG_PRESENCE);
            end
            PH_PRESENCE: begin
                if (lvl) begin
                    close_xfer(ERR_NO_PRESENCE);
                end else begin
                    byte_idx = '0;
                    bit_idx = '0;
                    arm(PH_RECOVERY, CFG_RECOVERY);
                end
            end
            PH_RECOVERY, PH_TX_GAP: next_tx_slot();
            PH_TX_START: begin
                drive_lvl = tx_mem[byte_idx[IDX_W-1:0]][bit_idx];
                arm(PH_TX_HOLD, CFG_SLOT_HOLD);
            end
            PH_TX_HOLD: begin
                drive_lvl = 1'b1;
                bit_idx = bit_idx + 3'd1;
                if (bit_idx == 0) begin
                    byte_idx = byte_idx + 1'b1;
                    arm(PH_TX_GAP, CFG_BYTE_GAP);
                end else begin
                    arm(PH_TX_GAP, CFG_BIT_GAP);
                end
            end
            PH_RX_START: begin
                drive_lvl = 1'b1;
                arm(PH_RX_WAIT, CFG_SAMPLE);
            end
            PH_RX_WAIT: begin
                rx_acc[bit_idx] = rx_acc[bit_idx] | lvl;
                bit_idx = bit_idx + 3'd1;
                if (bit_idx == 0) begin
                    res_now.rx_valid = 1'b1;
                    res_now.rx_byte = rx_acc;
                    res_now.rx_index = byte_idx[IDX_W-1:0];
                    byte_idx = byte_idx + 1'b1;
                    arm(PH_RX_GAP, CFG_BYTE_GAP);
                end else begin
                    arm(PH_RX_GAP, CFG_BIT_GAP);
                end
            end
            PH_RX_GAP: next_rx_slot();
            default: close_xfer(ERR_NONE);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        return (c > MAX_BYTES) ? CNT_W'(MAX_BYTES) : c;
    endfunction

    // Advance the sequencer by one transaction and return the result it gives
    function automatic t_result bus_result(input bus_item_t it);
        res_now = '0;
        case (it.op)
            OP_LOAD: tx_mem[it.idx] = it.lbyte;
            OP_START: begin
                if (bus_phase == PH_IDLE) begin
                    tx_cnt = clamp_count(it.scount);
                    rx_cnt = clamp_count(it.rcount);
                    byte_idx = '0;
                    bit_idx = '0;
                    rx_acc = '0;
                    if (!it.level) begin
                        close_xfer(ERR_PULLUP);
                    end else begin
                        err_code = ERR_NONE;
                        drive_lvl = 1'b0;
                        arm(PH_RESET_LOW, CFG_RESET_LOW);
                    end
                end
            end
            OP_TICK: begin
                if (bus_phase != PH_IDLE) begin
                    if (bus_countdown <= 1)
                        phase_expired(it.level);
                    else
                        bus_countdown = bus_countdown - 1'b1;
                end
            end
            default: ;
        endcase
        res_now.line_drive = drive_lvl;
        res_now.busy_res = (bus_phase != PH_IDLE);
        res_now.error_code = err_code;
        return res_now;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic issue(input t_op op, input int idx, input int lbyte, input int sc,
                         input int rc, input bit lvl);
        bus_item_t it;
        it.op = op;
        it.idx = IDX_W'(idx);
        it.lbyte = 8'(lbyte);
        it.scount = CNT_W'(sc);
        it.rcount = CNT_W'(rc);
        it.level = lvl;
        // transactions the block merely ignores do not count
        if (counting && op != OP_NOP && !(op == OP_TICK && bus_phase == PH_IDLE)
                && !(op == OP_START && bus_phase != PH_IDLE))
            rand_items++;
        pending_items.push_back(it);
        expected_results.push_back(bus_result(it));
    endtask

    // Bus level seen on a tick; a presence pulse answers only when wanted
    function automatic bit line_sample(input bit want_presence);
        if (bus_phase == PH_PRESENCE && bus_countdown <= 1)
            return !want_presence;
        return 1'($urandom_range(0, 1));
    endfunction

    // Tick until the transfer ends, with some loads, starts and no-ops mixed in
    task automatic run_transfer(input bit want_presence, input int noise);
        int r;
        while (bus_phase != PH_IDLE) begin
            r = $urandom_range(0, 99);
            if (r < noise / 2)
                issue(OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 255),
                      $urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
            else if (r < noise * 3 / 4)
                issue(OP_START, $urandom_range(0, 31), $urandom_range(0, 255),
                      $urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
            else if (r < noise)
                issue(OP_NOP, $urandom_range(0, 31), $urandom_range(0, 255),
                      $urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
            else
                issue(OP_TICK, $urandom_range(0, 31), $urandom_range(0, 255),
                      $urandom_range(0, 63), $urandom_range(0, 63), line_sample(want_presence));
        end
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain();
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all timing registers once the block has gone quiet
    task automatic apply_timing();
        drain();
        for (int i = 0; i < NUM_CFG; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= t_cfg_idx'(i);
            i_cfg_data <= next_timing[i];
            tim_regs[i] = next_timing[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_time pick_timing();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return t_time'($urandom_range(0, 3));
        if (r < 95)
            return t_time'($urandom_range(4, 12));
        return t_time'($urandom_range(13, 40));
    endfunction

    function automatic int pick_count();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 8);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_no;
        int phase_end;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timing: extremes of the load fields, no-op, ticks while idle,
        // pull-up fault, then a missing presence pulse
        issue(OP_LOAD, 0, 8'hFF, 0, 0, 1'b1);
        issue(OP_LOAD, 31, 8'h00, 63, 63, 1'b0);
        issue(OP_NOP, 31, 8'hFF, 63, 63, 1'b1);
        issue(OP_TICK, 0, 0, 0, 0, 1'b0);
        issue(OP_TICK, 0, 0, 0, 0, 1'b1);
        issue(OP_START, 0, 0, 1, 1, 1'b0);
        issue(OP_START, 0, 0, 1, 1, 1'b1);
        run_transfer(1'b0, 0);

        // Shortest timing: every value zero
        foreach (next_timing[i])
            next_timing[i] = '0;
        apply_timing();
        for (int i = 0; i < MAX_BYTES; i++)
            issue(OP_LOAD, i, $urandom_range(0, 255), 0, 0, 1'b1);
        issue(OP_START, 0, 0, 2, 1, 1'b1);
        repeat (3) issue(OP_TICK, 0, 0, 0, 0, line_sample(1'b1));
        // load and start while a transfer is running
        issue(OP_LOAD, 1, 8'h5A, 0, 0, 1'b1);
        issue(OP_START, 0, 0, 5, 5, 1'b1);
        run_transfer(1'b1, 0);
        issue(OP_START, 0, 0, 0, 0, 1'b1);
        run_transfer(1'b1, 0);
        issue(OP_START, 0, 0, 0, 2, 1'b1);
        run_transfer(1'b1, 0);
        // counts above the store size saturate
        issue(OP_START, 0, 0, 63, 63, 1'b1);
        run_transfer(1'b1, 0);

        // Longest timing
        foreach (next_timing[i])
            next_timing[i] = '1;
        apply_timing();
        issue(OP_START, 0, 0, 1, 1, 1'b1);
        run_transfer(1'b0, 0);

        // Random phases, each with its own timing
        counting = 1'b1;
        phase_no = 0;
        while (rand_items < RANDOM_ITEMS) begin
            foreach (next_timing[i])
                next_timing[i] = pick_timing();
            apply_timing();
            idle_on = (rand_items < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
            if (phase_no == 1)
                hold_req = 1'b1;
            phase_end = rand_items + 300;
            while (rand_items < phase_end) begin
                repeat ($urandom_range(0, 2))
                    issue(OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 255),
                          $urandom_range(0, 63), $urandom_range(0, 63),
                          1'($urandom_range(0, 1)));
                if ($urandom_range(0, 7) == 0)
                    issue(OP_NOP, $urandom_range(0, 31), $urandom_range(0, 255),
                          $urandom_range(0, 63), $urandom_range(0, 63),
                          1'($urandom_range(0, 1)));
                if ($urandom_range(0, 7) == 0)
                    issue(OP_TICK, $urandom_range(0, 31), $urandom_range(0, 255),
                          $urandom_range(0, 63), $urandom_range(0, 63),
                          1'($urandom_range(0, 1)));
                issue(OP_START, $urandom_range(0, 31), $urandom_range(0, 255),
                      pick_count(), pick_count(), $urandom_range(0, 19) != 0);
                run_transfer($urandom_range(0, 9) != 0, 8);
            end
            phase_no++;
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: presents queued transactions, with random gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        bus_item_t cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                gap_left <= $urandom_range(0, 15);
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                cur = pending_items.pop_front();
                i_op <= cur.op;
                i_load_index <= cur.idx;
                i_load_byte <= cur.lbyte;
                i_send_count <= cur.scount;
                i_receive_count <= cur.rcount;
                i_line_level <= cur.level;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output monitor and receiver stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
            burst_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("line_drive", want.line_drive, o_line_drive);
                    check_field("busy_res", want.busy_res, o_busy_res);
                    check_field("done_res", want.done_res, o_done_res);
                    check_field("error_code", want.error_code, o_error_code);
                    check_field("rx_valid", want.rx_valid, o_rx_valid);
                    check_field("rx_byte", want.rx_byte, o_rx_byte);
                    check_field("rx_index", want.rx_index, o_rx_index);
                end
            end
            // one long hold-off, then short random stall bursts
            if (hold_req && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (burst_left != 0) begin
                burst_left <= burst_left - 1;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                burst_left <= $urandom_range(0, 15);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

### sim.f
+incdir+hdl
hdl/owbm_pkg.sv
hdl/owbm_skid.sv
hdl/one_wire_bus_master_top.sv
hdl/owbm_checker.sv
bench/one_wire_bus_master_top_tb.sv
